>>> src/g2rp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2rp_pkg
// Shared types and constants for the 2bpp glyph row packer.
// ----------------------------------------------------------------------------
package g2rp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned OQ_DEPTH   = 4;
  localparam int unsigned OQ_PTR_W   = 2;
  localparam int unsigned OQ_CNT_W   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 8'd1;

  // one packed output byte
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_item_t;

  // up to two results produced by one source byte
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

>>> src/g2rp_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2rp_out_queue
// Small output queue: takes up to two bytes per cycle, hands out one.
// ----------------------------------------------------------------------------
module g2rp_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  g2rp_pkg::push_t     push,
  output logic                room_for_two,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,  // [7:0] packed_byte
  output logic                m_tlast   // last_of_glyph
);

  g2rp_pkg::out_item_t mem [g2rp_pkg::OQ_DEPTH];

  logic [g2rp_pkg::OQ_PTR_W-1:0] wr_ptr;
  logic [g2rp_pkg::OQ_PTR_W-1:0] rd_ptr;
  logic [g2rp_pkg::OQ_CNT_W-1:0] count;
  logic [g2rp_pkg::OQ_CNT_W-1:0] count_next;
  logic                          pop;

  assign pop          = m_tvalid && m_tready;
  assign m_tvalid     = (count != '0);
  assign m_tdata      = mem[rd_ptr].data;
  assign m_tlast      = mem[rd_ptr].last;
  assign room_for_two = (count <= g2rp_pkg::OQ_CNT_W'(g2rp_pkg::OQ_DEPTH - 2));
  assign count_next   = count + {1'b0, push.cnt} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.cnt;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.item1;
    end
  end

endmodule

>>> src/glyph_2bpp_row_packer_core.sv
`timescale 1ns / 1ps
// Output: a packed byte is queued when its source byte transfers in and is
//   offered on m_tvalid (two bytes per source byte at most, queued in order).
// Throughput: one source byte per clock; s_tready drops only when the
//   4-entry output queue has fewer than two free slots.
// Reset: rst clears the carry, row/byte position and queue; width and
//   height return to 1.
// ----------------------------------------------------------------------------
// glyph_2bpp_row_packer_core
// Drops the per-row byte padding of a 2bpp glyph bitmap and emits a
// continuous packed byte stream, flushing a partial byte at glyph end.
// ----------------------------------------------------------------------------
module glyph_2bpp_row_packer_core (
  input  logic       clk,
  input  logic       rst,
  // source stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] pixel_byte
  // packed stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] packed_byte
  output logic       m_tlast,    // last_of_glyph
  // register writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration
  logic [7:0] glyph_width;
  logic [7:0] glyph_height;

  // glyph walk state
  logic [5:0] pixel_carry;   // leftover pixels, right-aligned
  logic [2:0] carry_bits;    // valid bits in pixel_carry
  logic [5:0] byte_in_row;
  logic [7:0] row_index;

  logic [5:0] pixel_carry_next;
  logic [2:0] carry_bits_next;
  logic [5:0] byte_in_row_next;
  logic [7:0] row_index_next;

  logic       in_xfer;
  logic       room_for_two;

  // datapath
  logic [7:0]  w_eff;
  logic [7:0]  h_eff;
  logic [5:0]  stride_m1;     // bytes per row minus one
  logic        row_end;
  logic        glyph_end;
  logic [2:0]  npix;          // pixels taken from this byte, 1..4
  logic [3:0]  in_bits;
  logic [7:0]  pix;
  logic [13:0] acc;
  logic [3:0]  bits;
  logic        emit_full;
  logic [3:0]  rem_bits;
  logic [13:0] rem_acc;
  logic [7:0]  full_byte;
  logic [7:0]  flush_byte;
  logic        has_flush;

  g2rp_pkg::push_t push;

  assign cfg_ready = 1'b1;
  assign s_tready  = room_for_two;
  assign in_xfer   = s_tvalid && s_tready;

  // zero register values act as one
  assign w_eff     = (glyph_width  == 8'd0) ? 8'd1 : glyph_width;
  assign h_eff     = (glyph_height == 8'd0) ? 8'd1 : glyph_height;
  // ceil(w/4) - 1 == (w-1)/4 for w >= 1
  assign stride_m1 = w_eff[7:2] - {5'd0, (w_eff[1:0] == 2'd0)};
  assign row_end   = (byte_in_row >= stride_m1);
  assign glyph_end = row_end && (row_index >= (h_eff - 8'd1));

  // last byte of a row holds only the remaining pixels
  always_comb begin
    if (row_end) begin
      npix = {1'b0, (w_eff[1:0] - 2'd1)} + 3'd1;
    end else begin
      npix = 3'd4;
    end
  end

  assign in_bits = {npix, 1'b0};
  assign pix     = s_tdata >> (4'd8 - in_bits);
  assign acc     = ({8'd0, pixel_carry} << in_bits) | {6'd0, pix};
  assign bits    = {1'b0, carry_bits} + in_bits;

  assign emit_full  = (bits >= 4'd8);
  assign full_byte  = 8'(acc >> (bits - 4'd8));
  assign rem_bits   = emit_full ? (bits - 4'd8) : bits;
  assign rem_acc    = emit_full ? (acc & ((14'd1 << rem_bits) - 14'd1)) : acc;
  // flush is left-aligned, zero-filled low
  assign flush_byte = 8'(rem_acc << (4'd8 - rem_bits));
  assign has_flush  = glyph_end && (rem_bits != 4'd0);

  always_comb begin
    push            = '0;
    push.item1.data = flush_byte;
    push.item1.last = 1'b1;
    if (emit_full) begin
      push.item0.data = full_byte;
      push.item0.last = glyph_end && !has_flush;
    end else begin
      push.item0.data = flush_byte;
      push.item0.last = 1'b1;
    end
    if (in_xfer) begin
      push.cnt = {1'b0, emit_full} + {1'b0, has_flush};
    end
  end

  // next walk state
  always_comb begin
    pixel_carry_next = pixel_carry;
    carry_bits_next  = carry_bits;
    byte_in_row_next = byte_in_row;
    row_index_next   = row_index;
    if (in_xfer) begin
      if (glyph_end) begin
        pixel_carry_next = '0;
        carry_bits_next  = '0;
        byte_in_row_next = '0;
        row_index_next   = '0;
      end else begin
        pixel_carry_next = rem_acc[5:0];
        carry_bits_next  = rem_bits[2:0];
        if (row_end) begin
          byte_in_row_next = '0;
          row_index_next   = row_index + 8'd1;
        end else begin
          byte_in_row_next = byte_in_row + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= 8'd1;
      glyph_height <= 8'd1;
      pixel_carry  <= '0;
      carry_bits   <= '0;
      byte_in_row  <= '0;
      row_index    <= '0;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index == g2rp_pkg::REG_GLYPH_WIDTH ||
                  cfg_index == g2rp_pkg::REG_GLYPH_HEIGHT)) begin
      // a register write restarts the glyph
      if (cfg_index == g2rp_pkg::REG_GLYPH_WIDTH) begin
        glyph_width <= cfg_data;
      end else begin
        glyph_height <= cfg_data;
      end
      pixel_carry <= '0;
      carry_bits  <= '0;
      byte_in_row <= '0;
      row_index   <= '0;
    end else begin
      pixel_carry <= pixel_carry_next;
      carry_bits  <= carry_bits_next;
      byte_in_row <= byte_in_row_next;
      row_index   <= row_index_next;
    end
  end

  g2rp_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

>>> bench/glyph_2bpp_row_packer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_2bpp_row_packer_checker
// Watches the register, source and packed channels of the row packer, keeps
// its own model of the repacking state and compares every packed transfer
// against the oldest predicted byte.
// ----------------------------------------------------------------------------
module glyph_2bpp_row_packer_checker
  import g2rp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         errors,
  output int         pending
);

  logic [7:0] width_q;
  logic [7:0] height_q;
  logic [5:0] carry_q;     // leftover pixels, right-aligned, oldest highest
  logic [2:0] carry_n_q;   // valid bits in carry_q
  logic [5:0] col_q;       // next source byte within the row
  logic [7:0] row_q;

  out_item_t packed_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void restart_glyph();
    carry_q   = '0;
    carry_n_q = '0;
    col_q     = '0;
    row_q     = '0;
  endfunction

  // any write to a known register restarts the glyph; other indexes do nothing
  function automatic void apply_reg_write(input logic [7:0] idx, input logic [7:0] val);
    if (idx == REG_GLYPH_WIDTH) begin
      width_q = val;
      restart_glyph();
    end else if (idx == REG_GLYPH_HEIGHT) begin
      height_q = val;
      restart_glyph();
    end
  endfunction

  function automatic void repack_source_byte(input logic [7:0] src);
    int unsigned w, h, stride, npix, acc, nbits;
    logic        row_end, glyph_end;
    out_item_t   item;
    w         = (width_q == 0) ? 1 : width_q;     // zero reads as one
    h         = (height_q == 0) ? 1 : height_q;
    stride    = (w + 3) / 4;
    row_end   = (col_q >= stride - 1);
    glyph_end = row_end && (row_q >= h - 1);
    // last byte of a row keeps only the pixels inside the glyph
    npix  = row_end ? ((w - 1) % 4) + 1 : 4;
    acc   = (32'(carry_q) << (2 * npix)) | (32'(src) >> (8 - 2 * npix));
    nbits = carry_n_q + 2 * npix;
    if (nbits >= 8) begin
      item.data = 8'(acc >> (nbits - 8));
      item.last = glyph_end && (nbits == 8);
      packed_q.push_back(item);
      nbits = nbits - 8;
      acc   = acc & ((32'd1 << nbits) - 1);
    end
    if (glyph_end) begin
      // flush the partial byte left-aligned, zero-filled
      if (nbits > 0) begin
        item.data = 8'(acc << (8 - nbits));
        item.last = 1'b1;
        packed_q.push_back(item);
      end
      restart_glyph();
    end else begin
      carry_q   = acc[5:0];
      carry_n_q = nbits[2:0];
      if (row_end) begin
        col_q = '0;
        row_q = row_q + 8'd1;
      end else begin
        col_q = col_q + 6'd1;
      end
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      width_q  = 8'd1;
      height_q = 8'd1;
      restart_glyph();
      packed_q.delete();
    end else begin
      // compare before predicting: a byte accepted now cannot leave now
      if (m_tvalid && m_tready) begin
        if (packed_q.size() == 0) begin
          $display("%0t: unexpected packed transfer, got data %02h last %0b",
                   $time, m_tdata, m_tlast);
          errors <= errors + 1;
        end else begin
          want = packed_q.pop_front();
          if (m_tdata !== want.data || m_tlast !== want.last) begin
            $display("%0t: packed mismatch, expected data %02h last %0b, got data %02h last %0b",
                     $time, want.data, want.last, m_tdata, m_tlast);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) repack_source_byte(s_tdata);
    end
    pending <= packed_q.size();
  end

endmodule

>>> bench/glyph_2bpp_row_packer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_2bpp_row_packer_core_tb
// Drives register writes and padded glyph bitmaps into the row packer with
// random gaps on both streams; the checker predicts and compares the packed
// stream and this top gives the verdict.
// ----------------------------------------------------------------------------
module glyph_2bpp_row_packer_core_tb;

  localparam int          ITEMS     = 1850;       // random source bytes
  localparam int          LIMIT     = 1_000_000;  // cycle budget for the run
  localparam int          SETTLE    = 4;          // settle time once nothing is pending
  localparam logic [7:0]  REG_SPARE = 8'd7;       // index with no register

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'h00;   // [7:0] pixel_byte
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;             // [7:0] packed_byte
  logic       m_tlast;             // last_of_glyph
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data  = 8'h00;

  int          errors;
  int          pending;
  int          cycles    = 0;
  int unsigned sink_hold = 0;
  bit          steady    = 1'b0;   // no gaps on either side while set
  int          sent      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glyph_2bpp_row_packer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_2bpp_row_packer_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // mostly no gap, some short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("glyph_2bpp_row_packer_core_tb: done, errors");
      $finish;
    end
  end

  // packed side: ready and stall stretches of random length
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready  <= ($urandom_range(0, 3) != 0);
      sink_hold <= gap_len();
    end
  end

  // hold off until every predicted byte has been seen, then let the pipe empty
  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic program_reg(input logic [7:0] idx, input logic [7:0] val);
    s_tvalid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one source transfer; with no gap tvalid stays high into the next byte
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  // stops early once the item budget is used up
  task automatic send_glyph(input int nbytes);
    for (int i = 0; i < nbytes && sent < ITEMS; i++) begin
      send_byte(8'($urandom_range(0, 255)));
      sent++;
    end
  endtask

  initial begin
    int          pick, nglyph, total;
    int unsigned w, h, eff_w, eff_h;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // reset values: one-pixel glyphs, all-ones and all-zeros sources
    send_byte(8'hFF);
    send_byte(8'h00);
    // zero width and height read as one
    program_reg(g2rp_pkg::REG_GLYPH_WIDTH, 8'd0);
    program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'd0);
    send_byte(8'hBF);
    // whole-byte width passes bytes straight through
    program_reg(g2rp_pkg::REG_GLYPH_WIDTH, 8'd4);
    program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'd1);
    send_byte(8'hA5);
    // three pixels carried across the row boundary
    program_reg(g2rp_pkg::REG_GLYPH_WIDTH, 8'd7);
    program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'd2);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    // two-pixel tail, three rows, partial flush at the end
    program_reg(g2rp_pkg::REG_GLYPH_WIDTH, 8'd6);
    program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'd3);
    send_byte(8'h1B);
    send_byte(8'hE4);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h93);
    send_byte(8'h6C);
    // register write in mid glyph drops the carry and restarts
    program_reg(g2rp_pkg::REG_GLYPH_WIDTH, 8'd5);
    program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'd2);
    send_byte(8'h5A);
    program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'd2);
    send_byte(8'hC3);
    send_byte(8'h3C);
    send_byte(8'h0F);
    send_byte(8'hF0);
    // write to an index with no register leaves the glyph running
    program_reg(g2rp_pkg::REG_GLYPH_WIDTH, 8'd3);
    program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'd2);
    send_byte(8'h96);
    program_reg(REG_SPARE, 8'h77);
    send_byte(8'h69);

    // --- random glyphs, mostly small, a few at the extremes ---
    while (sent < ITEMS) begin
      steady = ($urandom_range(0, 6) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 3) begin
        w = 255;
        h = $urandom_range(1, 2);
      end else if (pick < 6) begin
        w = $urandom_range(1, 8);
        h = 255;
      end else if (pick < 9) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        h = $urandom_range(0, 3);
      end else begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 1)) begin
        program_reg(g2rp_pkg::REG_GLYPH_WIDTH, 8'(w));
        program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'(h));
      end else begin
        program_reg(g2rp_pkg::REG_GLYPH_HEIGHT, 8'(h));
        program_reg(g2rp_pkg::REG_GLYPH_WIDTH, 8'(w));
      end
      eff_w  = (w == 0) ? 1 : w;
      eff_h  = (h == 0) ? 1 : h;
      total  = ((eff_w + 3) / 4) * eff_h;
      nglyph = $urandom_range(1, 3);
      for (int g = 0; g < nglyph; g++) begin
        // occasionally cut the final glyph short; the next write restarts it
        if (g == nglyph - 1 && total > 1 && $urandom_range(0, 9) == 0)
          send_glyph($urandom_range(1, total - 1));
        else
          send_glyph(total);
      end
    end

    s_tvalid <= 1'b0;
    steady = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("glyph_2bpp_row_packer_core_tb: done, clean");
    end else begin
      $display("glyph_2bpp_row_packer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
